// File: hdl/bspq_pkg.sv
// Shared types and constants of the bounded stable priority queue.
`timescale 1ns / 1ps
package bspq_pkg;
  localparam int KEY_W = 32;

  typedef enum logic {
    OP_ENQ   = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic {
    S_RUN  = 1'b0,
    S_EMIT = 1'b1
  } back_state_t;

  // Handshake between the request queue and the back end.
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctrl_t;
endpackage

// File: hdl/bspq_front.sv
// Front end: holds the enable register and classifies accepted requests.
`timescale 1ns / 1ps
module bspq_front import bspq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic mode,
  input  logic full,
  input  logic cfg_we,
  input  logic cfg_data,
  output logic busy,
  output logic push,
  output op_t  op
);
  logic queue_enabled;

  // Enable register, set after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_enabled <= 1'b1;
    end else if (cfg_we) begin
      queue_enabled <= cfg_data;
    end
  end

  // A disabled block takes the request and discards it.
  assign busy = full;
  assign push = start && !full && queue_enabled;
  assign op   = (mode == 1'b1) ? OP_FLUSH : OP_ENQ;
endmodule

// File: hdl/bspq_fifo.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
module bspq_fifo import bspq_pkg::*; #(
  parameter int W = 97
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  output q_ctrl_t      ctrl_out,
  input  logic         pop,
  output logic [W-1:0] rdata
);
  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0] fill;
  logic do_pop;

  assign do_pop = pop && (fill != '0);
  assign full = (fill == (AW+1)'(DEPTH));
  assign ctrl_out.valid = (fill != '0);
  assign ctrl_out.pop = do_pop;
  assign rdata = mem[rptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill + (AW+1)'(push && !full) - (AW+1)'(do_pop);
    end
  end
endmodule

// File: hdl/bspq_back.sv
// Back end: sorted insertion row and the flush sequencer.
`timescale 1ns / 1ps
module bspq_back import bspq_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  q_ctrl_t                 q_ctrl,
  input  op_t                     op,
  input  logic signed [KEY_W-1:0] key_in,
  input  logic [PAYLOAD_BITS-1:0] payload_in,
  output logic                    pop,
  output logic                    out_valid,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic signed [KEY_W-1:0] out_key,
  output logic                    last,
  output logic                    overflowed
);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [KEY_W-1:0] cell_k [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_p [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CW-1:0] count;
  logic drop_mark;
  logic ovf_hold;
  back_state_t state, state_next;
  logic do_ins;
  logic do_drop;
  logic do_flush;
  logic do_emit;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_RUN: begin
        if (q_ctrl.valid && op == OP_FLUSH && count != '0) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (count == CW'(1)) begin
          state_next = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop = 1'b0;
    do_ins = 1'b0;
    do_drop = 1'b0;
    do_flush = 1'b0;
    do_emit = 1'b0;
    case (state)
      S_RUN: begin
        pop = q_ctrl.valid;
        if (q_ctrl.valid && op == OP_ENQ) begin
          do_ins = (count < CW'(CAPACITY));
          do_drop = (count >= CW'(CAPACITY));
        end
        do_flush = q_ctrl.valid && op == OP_FLUSH && count != '0;
      end
      S_EMIT: do_emit = 1'b1;
      default: pop = 1'b0;
    endcase
  end

  // Each cell asks whether the new key goes ahead of it; empty cells always yield.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (i >= int'(count)) || (cell_k[i] > key_in);
    end
  end

  // Cell row: shift right on insertion, shift left on emission.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_ins && gt[i]) begin
        if (i > 0 && gt[(i > 0) ? i-1 : 0]) begin
          cell_k[i] <= cell_k[(i > 0) ? i-1 : 0];
          cell_p[i] <= cell_p[(i > 0) ? i-1 : 0];
        end else begin
          cell_k[i] <= key_in;
          cell_p[i] <= payload_in;
        end
      end else if (do_emit && i < CAPACITY-1) begin
        cell_k[i] <= cell_k[(i < CAPACITY-1) ? i+1 : i];
        cell_p[i] <= cell_p[(i < CAPACITY-1) ? i+1 : i];
      end
    end
  end

  // Count, drop mark, overflow hold, result valid and state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      count <= '0;
      drop_mark <= 1'b0;
      ovf_hold <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= do_emit;
      if (do_ins) begin
        count <= count + 1'b1;
      end
      if (do_drop) begin
        drop_mark <= 1'b1;
      end
      if (do_flush) begin
        ovf_hold <= drop_mark;
        drop_mark <= 1'b0;
      end
      if (do_emit) begin
        count <= count - 1'b1;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_key <= cell_k[0];
      out_payload <= cell_p[0];
      last <= (count == CW'(1));
      overflowed <= ovf_hold;
    end
  end

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(state == S_EMIT)) else $error("result outside emission");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("count beyond capacity");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |=> !out_valid) else $error("result after last");
  a_no_pop_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> !pop) else $error("request taken during flush");
endmodule

// File: hdl/bounded_stable_priority_queue.sv
// Top level of the bounded stable priority queue.
`timescale 1ns / 1ps
// Requests enter at one per cycle while busy is low; busy rises only when the
// four-entry request queue fills, which happens while a flush is emitting.
// An enqueue is inserted into a sorted row of registers. A flush of n items
// emits one result per cycle after it reaches the back end, and the results
// cannot be held off, so a result appears on out_valid for one cycle only.
// Ties keep submission order. The store needs no clearing after reset: only
// the item count marks valid entries.
module bounded_stable_priority_queue import bspq_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    mode,
  input  logic signed [KEY_W-1:0] sort_key,
  input  logic [PAYLOAD_BITS-1:0] payload,
  input  logic                    cfg_we,
  input  logic                    cfg_data,
  output logic                    out_valid,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic signed [KEY_W-1:0] out_key,
  output logic                    last,
  output logic                    overflowed
);
  localparam int W = 1 + KEY_W + PAYLOAD_BITS;

  logic push;
  op_t op_f;
  logic full;
  q_ctrl_t q_ctrl;
  logic pop;
  logic [W-1:0] rdata;

  bspq_front u_front (
    .clk(clk), .rst(rst), .start(start), .mode(mode), .full(full),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .busy(busy), .push(push), .op(op_f)
  );

  bspq_fifo #(.W(W)) u_fifo (
    .clk(clk), .rst(rst), .push(push),
    .wdata({op_f, sort_key, payload}), .full(full), .ctrl_out(q_ctrl),
    .pop(pop), .rdata(rdata)
  );

  bspq_back #(.CAPACITY(CAPACITY), .PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
    .clk(clk), .rst(rst), .q_ctrl(q_ctrl), .op(op_t'(rdata[W-1])),
    .key_in(rdata[W-2:PAYLOAD_BITS]), .payload_in(rdata[PAYLOAD_BITS-1:0]),
    .pop(pop), .out_valid(out_valid), .out_payload(out_payload),
    .out_key(out_key), .last(last), .overflowed(overflowed)
  );
endmodule
